// ===== sv/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants for the ray/box slab intersection core.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int DATA_W            = 32;  // width of every coordinate
    localparam int NUM_AXES          = 3;
    localparam int NUM_LANES         = 2 * NUM_AXES;  // min planes, then max planes
    localparam int BITS_PER_STAGE    = 4;   // quotient bits resolved per divider stage
    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int IN_TDATA_W        = 12 * DATA_W;
    localparam int OUT_FIELDS_W      = 1 + 2 * DATA_W;
    localparam int OUT_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== sv/ray_box_slab_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core
// Fixed-point ray against axis-aligned box test, slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one test per transaction: box min corner, box max corner,
//   ray origin and ray direction, all signed fixed point with FRAC_BITS
//   fraction bits. m_axis returns one transaction per test: hit, t_near and
//   t_far (both zero on a miss, saturated to 32 bits on a hit).
// Throughput: one transaction per cycle, sustained while m_axis_tready is high.
// Depth: the input register, NDIV divider stages, then stages A, B and C
//   lie between acceptance and m_axis_tvalid; NDIV = ceil((32 + FRAC_BITS) / 4).
//   The six plane quotients each run through a restoring divider of NDIV
//   stages, four quotient bits per stage, which sets the depth.
// Stall: the whole pipe advances together when m_axis_tready is high or the
//   output register is empty; s_axis_tready follows that, so while a finished
//   result waits the whole pipe holds, bubbles included. Nothing is dropped
//   or repeated across a stall.
// Reset: rst_n clears every valid bit; payload registers are not reset.
// Zero direction on an axis: unbounded when the origin lies inside that
//   slab, otherwise the test is a miss.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_core #(
    parameter int FRAC_BITS = rbsi_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // box_min_x/y/z, box_max_x/y/z, origin_x/y/z, direction_x/y/z (lowest first)
    input  logic [rbsi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit, t_near, t_far, zero pad (lowest first)
    output logic [rbsi_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DW    = rbsi_pkg::DATA_W;
    localparam int NL    = rbsi_pkg::NUM_LANES;
    localparam int NA    = rbsi_pkg::NUM_AXES;
    localparam int BPS   = rbsi_pkg::BITS_PER_STAGE;
    localparam int NW    = DW + FRAC_BITS;          // dividend / quotient width
    localparam int NDIV  = (NW + BPS - 1) / BPS;    // divider stages
    localparam int RW    = DW + 1;                  // partial remainder width
    localparam int TW    = NW + 2;                  // signed distance width
    localparam logic signed [TW-1:0] T_NEG_INF = {2'b10, {(TW-2){1'b0}}};
    localparam logic signed [TW-1:0] T_POS_INF = {2'b01, {(TW-2){1'b1}}};
    localparam logic signed [TW-1:0] SAT_HI = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_LO = -TW'(64'sd2147483648);

    // global advance
    logic adv;
    assign adv           = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;

    // ------------------------------------------------------------------
    // divider pipe: index 0 is the input register
    // ------------------------------------------------------------------
    logic          v_reg    [0:NDIV];
    logic [NW-1:0] dq_reg   [0:NDIV][0:NL-1];  // dividend shifting out, quotient in
    logic [RW-1:0] rem_reg  [0:NDIV][0:NL-1];
    logic [DW-1:0] den_reg  [0:NDIV][0:NA-1];
    logic          neg_reg  [0:NDIV][0:NL-1];
    logic [NA-1:0] dz_reg   [0:NDIV];          // direction component is zero
    logic [NA-1:0] out_reg  [0:NDIV];          // origin outside slab

    // input stage
    logic [NW-1:0] dq_next  [0:NL-1];
    logic          neg_next [0:NL-1];
    logic [DW-1:0] den_next [0:NA-1];
    logic [NA-1:0] dz_next, out_next;

    always_comb
    begin
        logic signed [DW-1:0] lo, hi, org, dir;
        logic signed [DW:0]   dlo, dhi;
        logic        [DW:0]   mlo, mhi;
        for (int a = 0; a < NA; a++)
        begin
            lo  = s_axis_tdata[a*DW +: DW];
            hi  = s_axis_tdata[(NA+a)*DW +: DW];
            org = s_axis_tdata[(2*NA+a)*DW +: DW];
            dir = s_axis_tdata[(3*NA+a)*DW +: DW];
            dlo = (DW+1)'(lo) - (DW+1)'(org);
            dhi = (DW+1)'(hi) - (DW+1)'(org);
            mlo = dlo[DW] ? (DW+1)'(-dlo) : (DW+1)'(dlo);
            mhi = dhi[DW] ? (DW+1)'(-dhi) : (DW+1)'(dhi);
            dq_next[a]     = {mlo[DW-1:0], {FRAC_BITS{1'b0}}};
            dq_next[NA+a]  = {mhi[DW-1:0], {FRAC_BITS{1'b0}}};
            neg_next[a]    = dlo[DW] ^ dir[DW-1];
            neg_next[NA+a] = dhi[DW] ^ dir[DW-1];
            den_next[a]    = dir[DW-1] ? DW'(-dir) : DW'(dir);
            dz_next[a]     = (dir == '0);
            out_next[a]    = (org < lo) || (org > hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NL; l++)
            begin
                dq_reg[0][l]  <= dq_next[l];
                rem_reg[0][l] <= '0;
                neg_reg[0][l] <= neg_next[l];
            end
            for (int a = 0; a < NA; a++)
            begin
                den_reg[0][a] <= den_next[a];
            end
            dz_reg[0]  <= dz_next;
            out_reg[0] <= out_next;
        end
    end

    // restoring divider stages
    for (genvar s = 0; s < NDIV; s++)
    begin : g_div
        logic [NW-1:0] dq_s  [0:NL-1];
        logic [RW-1:0] rem_s [0:NL-1];

        always_comb
        begin
            logic [NW-1:0] dq;
            logic [RW-1:0] r;
            logic [RW-1:0] d;
            for (int l = 0; l < NL; l++)
            begin
                dq = dq_reg[s][l];
                r  = rem_reg[s][l];
                d  = {1'b0, den_reg[s][l % NA]};
                for (int k = 0; k < BPS; k++)
                begin
                    if (s * BPS + k < NW)
                    begin
                        r  = {r[RW-2:0], dq[NW-1]};
                        dq = {dq[NW-2:0], 1'b0};
                        if (r >= d)
                        begin
                            r     = r - d;
                            dq[0] = 1'b1;
                        end
                    end
                end
                dq_s[l]  = dq;
                rem_s[l] = r;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    dq_reg[s+1][l]  <= dq_s[l];
                    rem_reg[s+1][l] <= rem_s[l];
                    neg_reg[s+1][l] <= neg_reg[s][l];
                end
                for (int a = 0; a < NA; a++)
                begin
                    den_reg[s+1][a] <= den_reg[s][a];
                end
                dz_reg[s+1]  <= dz_reg[s];
                out_reg[s+1] <= out_reg[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage A: signed quotients, per-axis entry and exit
    // ------------------------------------------------------------------
    logic                 va_reg;
    logic signed [TW-1:0] ent_reg [0:NA-1];
    logic signed [TW-1:0] lv_reg  [0:NA-1];
    logic                 missa_reg;
    logic signed [TW-1:0] ent_next [0:NA-1];
    logic signed [TW-1:0] lv_next  [0:NA-1];
    logic                 missa_next;

    always_comb
    begin
        logic signed [TW-1:0] qa, qb;
        missa_next = 1'b0;
        for (int a = 0; a < NA; a++)
        begin
            qa = $signed({2'b00, dq_reg[NDIV][a]});
            qb = $signed({2'b00, dq_reg[NDIV][NA+a]});
            if (neg_reg[NDIV][a])
            begin
                qa = -qa;
            end
            if (neg_reg[NDIV][NA+a])
            begin
                qb = -qb;
            end
            if (dz_reg[NDIV][a])
            begin
                ent_next[a] = T_NEG_INF;
                lv_next[a]  = T_POS_INF;
                missa_next  = missa_next | out_reg[NDIV][a];
            end
            else
            begin
                ent_next[a] = (qa < qb) ? qa : qb;
                lv_next[a]  = (qa < qb) ? qb : qa;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage B: largest entry, smallest exit
    // ------------------------------------------------------------------
    logic                 vb_reg;
    logic signed [TW-1:0] tn_reg, tf_reg;
    logic                 missb_reg;
    logic signed [TW-1:0] tn_next, tf_next;

    always_comb
    begin
        tn_next = ent_reg[0];
        tf_next = lv_reg[0];
        for (int a = 1; a < NA; a++)
        begin
            if (ent_reg[a] > tn_next)
            begin
                tn_next = ent_reg[a];
            end
            if (lv_reg[a] < tf_next)
            begin
                tf_next = lv_reg[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage C: hit decision and saturation into the output register
    // ------------------------------------------------------------------
    logic                 vc_reg;
    logic                 hit_reg;
    logic signed [DW-1:0] tnear_reg, tfar_reg;
    logic                 hit_next;
    logic signed [DW-1:0] tnear_next, tfar_next;

    always_comb
    begin
        hit_next = !missb_reg && !(tn_reg > tf_reg);
        if (tn_reg > SAT_HI)
        begin
            tnear_next = DW'(SAT_HI);
        end
        else if (tn_reg < SAT_LO)
        begin
            tnear_next = DW'(SAT_LO);
        end
        else
        begin
            tnear_next = DW'(tn_reg);
        end
        if (tf_reg > SAT_HI)
        begin
            tfar_next = DW'(SAT_HI);
        end
        else if (tf_reg < SAT_LO)
        begin
            tfar_next = DW'(SAT_LO);
        end
        else
        begin
            tfar_next = DW'(tf_reg);
        end
        if (!hit_next)
        begin
            tnear_next = '0;
            tfar_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= v_reg[NDIV];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NA; a++)
            begin
                ent_reg[a] <= ent_next[a];
                lv_reg[a]  <= lv_next[a];
            end
            missa_reg <= missa_next;
            tn_reg    <= tn_next;
            tf_reg    <= tf_next;
            missb_reg <= missa_reg;
            hit_reg   <= hit_next;
            tnear_reg <= tnear_next;
            tfar_reg  <= tfar_next;
        end
    end

    assign m_axis_tvalid = vc_reg;
    assign m_axis_tdata  = {{(rbsi_pkg::OUT_TDATA_W - rbsi_pkg::OUT_FIELDS_W){1'b0}},
                            tfar_reg, tnear_reg, hit_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg && !hit_reg) |-> (tnear_reg == '0 && tfar_reg == '0))
        else $error("miss with non-zero distances");

    a_hit_order : assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg && hit_reg) |-> (tnear_reg <= tfar_reg))
        else $error("hit with t_near beyond t_far");

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted transaction not in input register");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vb_reg) && $stable(va_reg)))
        else $error("pipe moved during stall");

endmodule
